[hw/rtl/swwa_pkg.sv]
// ----------------------------------------------------------------------------
// Sine wave warp address package
// Sizes, register codes, reset values, the quarter-wave sine table and the
// divider step functions for the core; the interfaces take their sizes from it.
// ----------------------------------------------------------------------------
`default_nettype none

package swwa_pkg;

    localparam int MAX_DIM        = 4096;
    localparam int SINE_ROM_DEPTH = 1024;

    localparam int COORD_W    = 12;
    localparam int FRAC_W     = 16;
    localparam int FREQ_W     = 16;
    localparam int ANGLE_W    = 16;
    localparam int SIZE_REG_W = 13;
    localparam int SINE_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DIM_W  = $clog2(MAX_DIM) + 1;
    localparam int AMP_W  = DIM_W - 1;
    localparam int ROM_AW = $clog2(SINE_ROM_DEPTH);
    localparam int IDX_SH = ANGLE_W - 2 - ROM_AW;
    localparam int AD_W   = FREQ_W + COORD_W + 8;
    localparam int PROD_W = AMP_W + 1 + SINE_W + 1;
    localparam int OFF_W  = AMP_W + 1;
    localparam int SUM_W  = ((COORD_W > AMP_W + 1) ? COORD_W : AMP_W + 1) + 1;
    localparam int NUM_W  = SUM_W + AMP_W + 1;
    localparam int MAG_W  = NUM_W;
    localparam int N_STG  = AD_W + 8 + MAG_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_Y       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_X      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_Y      = 3'd7;

    localparam logic [SIZE_REG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [SIZE_REG_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [FRAC_W-1:0]     RST_AMP          = 16'd3932;
    localparam logic [FREQ_W-1:0]     RST_FREQ         = 16'd1024;
    localparam logic [ANGLE_W-1:0]    RST_PHASE        = 16'd0;

    typedef logic [SINE_W-1:0] t_sine_rom [0:SINE_ROM_DEPTH];

    typedef struct packed {
        logic [AD_W-1:0]    dvd;
        logic [DIM_W-1:0]   rem;
        logic [ANGLE_W-1:0] quo;
        logic               neg;
    } t_adiv;

    typedef struct packed {
        logic [MAG_W-1:0] acc;
        logic [AMP_W-1:0] rem;
        logic             neg;
    } t_wdiv;

    function automatic logic [SINE_W-1:0] quarter_rom(input int r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x  = 64'(r) * 64'd1686629713 / 64'(SINE_ROM_DEPTH);
        x2 = (x * x) >> 30;
        t  = 64'd1073741824 - x2 / 64'd72;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        v  = (s + 64'd16384) >> 15;
        return (v > 64'd32767) ? 15'h7FFF : v[SINE_W-1:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int i = 0; i <= SINE_ROM_DEPTH; i++) begin
            rom[i] = quarter_rom(i);
        end
        return rom;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_size(input logic [SIZE_REG_W-1:0] v);
        if (32'(v) < 2) begin
            return DIM_W'(2);
        end else if (32'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    function automatic logic [AMP_W-1:0] amp_pixels(input logic [FRAC_W-1:0] frac,
                                                    input logic [DIM_W-1:0] size);
        logic [FRAC_W+DIM_W:0] a;
        logic [DIM_W-1:0]      hi;
        a  = ((FRAC_W+DIM_W+1)'(frac) * (FRAC_W+DIM_W+1)'(size)
              + (FRAC_W+DIM_W+1)'(65536)) >> 17;
        hi = (size >> 1) - DIM_W'(1);
        if (a > (FRAC_W+DIM_W+1)'(hi)) begin
            a = (FRAC_W+DIM_W+1)'(hi);
        end
        return AMP_W'(a);
    endfunction

    function automatic t_adiv adiv_step(input t_adiv s, input logic [DIM_W-1:0] d);
        t_adiv        n;
        logic [DIM_W:0] trial;
        n     = s;
        trial = {s.rem, s.dvd[AD_W-1]};
        n.dvd = {s.dvd[AD_W-2:0], 1'b0};
        if (trial >= {1'b0, d}) begin
            n.rem = DIM_W'(trial - {1'b0, d});
            n.quo = {s.quo[ANGLE_W-2:0], 1'b1};
        end else begin
            n.rem = trial[DIM_W-1:0];
            n.quo = {s.quo[ANGLE_W-2:0], 1'b0};
        end
        return n;
    endfunction

    function automatic t_wdiv wdiv_step(input t_wdiv s, input logic [AMP_W-1:0] d);
        t_wdiv          n;
        logic [AMP_W:0] trial;
        n     = s;
        trial = {s.rem, s.acc[MAG_W-1]};
        if (trial >= {1'b0, d}) begin
            n.rem = AMP_W'(trial - {1'b0, d});
            n.acc = {s.acc[MAG_W-2:0], 1'b1};
        end else begin
            n.rem = trial[AMP_W-1:0];
            n.acc = {s.acc[MAG_W-2:0], 1'b0};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/swwa_if.sv]
// ----------------------------------------------------------------------------
// Sine wave warp address channels
// Valid/ready channels for output pixel coordinates, source coordinates and
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface swwa_pix_if import swwa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    modport source (output valid, output out_x, output out_y, input ready);
    modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

interface swwa_src_if import swwa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic               in_range;
    modport source (output valid, output src_x, output src_y, output in_range, input ready);
    modport sink   (input valid, input src_x, input src_y, input in_range, output ready);
endinterface

interface swwa_cfg_if import swwa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/sine_wave_warp_address_core.sv]
// ----------------------------------------------------------------------------
// Sine wave warp address core
// Maps each output pixel coordinate to the source coordinate of a sinusoidal
// wave warp. Coordinates enter on i_pix and results leave on o_src; both are
// valid/ready channels and a transaction completes when valid and ready are
// high at a rising edge. Registers are written on i_cfg, which is always
// ready; write them only while no transaction is in flight.
// A coordinate may be accepted every cycle while o_src is not stalled; it
// passes an input register, a 36 step long division for the wave angle, the
// angle, sine, product, offset, sum, numerator and load registers, a 27 step
// long division for the rescale, one bit per stage, and the output register.
// The whole pipeline advances together; when o_src is stalled, i_pix.ready
// drops in the same cycle and every stage holds its contents. A synchronous
// active-low reset empties the pipeline and restores the register defaults;
// no clearing pass follows.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_wave_warp_address_core import swwa_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    swwa_pix_if.sink   i_pix,
    swwa_src_if.source o_src,
    swwa_cfg_if.sink   i_cfg
);

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    logic [SIZE_REG_W-1:0]    r_frame_w;
    logic [SIZE_REG_W-1:0]    r_frame_h;
    logic [FRAC_W-1:0]        r_amp_frac [0:1];
    logic signed [FREQ_W-1:0] r_freq     [0:1];
    logic [ANGLE_W-1:0]       r_phase    [0:1];

    logic [DIM_W-1:0] r_size [0:1];
    logic [AMP_W-1:0] r_amp  [0:1];
    logic [AMP_W-1:0] r_sm1  [0:1];
    logic [AMP_W-1:0] r_wdv  [0:1];

    logic [N_STG-1:0] r_vld;
    logic             r_ov;
    logic             w_adv;
    logic             w_acc;

    t_adiv              r_ad  [0:AD_W][0:1];
    logic [COORD_W-1:0] r_ac  [0:AD_W][0:1];
    logic [COORD_W-1:0] r_pc  [0:3][0:1];
    logic [ANGLE_W-1:0] r_ang [0:1];
    logic [SINE_W-1:0]  r_mag [0:1];
    logic               r_sneg [0:1];
    logic signed [PROD_W-1:0] r_prod [0:1];
    logic signed [OFF_W-1:0]  r_off  [0:1];
    logic signed [SUM_W-1:0]  r_sum  [0:1];
    logic signed [NUM_W-1:0]  r_num  [0:1];
    t_wdiv              r_wd  [0:MAG_W][0:1];

    logic [COORD_W-1:0] r_src_x;
    logic [COORD_W-1:0] r_src_y;
    logic               r_in_range;

    logic [FREQ_W-1:0]         w_fmag  [0:1];
    logic [FREQ_W+COORD_W-1:0] w_fprod [0:1];
    logic [ANGLE_W-1:0]        w_qlow  [0:1];
    logic [ROM_AW+1:0]         w_idx   [0:1];
    logic [ROM_AW:0]           w_addr  [0:1];
    logic signed [SINE_W:0]    w_sine  [0:1];
    logic [PROD_W-1:0]         w_pmag  [0:1];
    logic [PROD_W:0]           w_rnd   [0:1];
    logic                      w_ok    [0:1];
    logic                      w_all_ok;

    assign w_adv       = !r_ov || o_src.ready;
    assign i_pix.ready = w_adv;
    assign w_acc       = i_pix.valid && w_adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w     <= RST_FRAME_WIDTH;
            r_frame_h     <= RST_FRAME_HEIGHT;
            r_amp_frac[0] <= RST_AMP;
            r_amp_frac[1] <= RST_AMP;
            r_freq[0]     <= RST_FREQ;
            r_freq[1]     <= RST_FREQ;
            r_phase[0]    <= RST_PHASE;
            r_phase[1]    <= RST_PHASE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_FRAME_WIDTH:  r_frame_w     <= i_cfg.data[SIZE_REG_W-1:0];
                REG_FRAME_HEIGHT: r_frame_h     <= i_cfg.data[SIZE_REG_W-1:0];
                REG_AMP_X:        r_amp_frac[0] <= i_cfg.data;
                REG_AMP_Y:        r_amp_frac[1] <= i_cfg.data;
                REG_FREQ_X:       r_freq[0]     <= i_cfg.data;
                REG_FREQ_Y:       r_freq[1]     <= i_cfg.data;
                REG_PHASE_X:      r_phase[0]    <= i_cfg.data;
                REG_PHASE_Y:      r_phase[1]    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_size[0] <= clamp_size(r_frame_w);
        r_size[1] <= clamp_size(r_frame_h);
        for (int c = 0; c < 2; c++) begin
            r_amp[c] <= amp_pixels(r_amp_frac[c], r_size[c]);
            r_sm1[c] <= AMP_W'(r_size[c] - DIM_W'(1));
            r_wdv[c] <= r_sm1[c] - {r_amp[c][AMP_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else if (w_adv) begin
            r_vld <= {r_vld[N_STG-2:0], w_acc};
            r_ov  <= r_vld[N_STG-1];
        end
    end

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_fmag[c] = r_freq[c][FREQ_W-1] ? FREQ_W'(-r_freq[c]) : FREQ_W'(r_freq[c]);
            if (r_ad[AD_W][c].neg) begin
                w_qlow[c] = (r_ad[AD_W][c].rem != '0) ? ~r_ad[AD_W][c].quo
                                                      : -r_ad[AD_W][c].quo;
            end else begin
                w_qlow[c] = r_ad[AD_W][c].quo;
            end
            w_idx[c] = r_ang[c][ANGLE_W-1:IDX_SH];
            if (w_idx[c][ROM_AW]) begin
                w_addr[c] = (ROM_AW+1)'(SINE_ROM_DEPTH) - {1'b0, w_idx[c][ROM_AW-1:0]};
            end else begin
                w_addr[c] = {1'b0, w_idx[c][ROM_AW-1:0]};
            end
            w_sine[c] = r_sneg[c] ? -$signed({1'b0, r_mag[c]}) : $signed({1'b0, r_mag[c]});
            w_pmag[c] = r_prod[c][PROD_W-1] ? PROD_W'(-r_prod[c]) : PROD_W'(r_prod[c]);
            w_rnd[c]  = ((PROD_W+1)'(w_pmag[c]) + (PROD_W+1)'(16384)) >> 15;
            w_ok[c]   = !(r_wd[MAG_W][c].neg && r_wd[MAG_W][c].acc != '0)
                        && (r_wd[MAG_W][c].acc < MAG_W'(r_size[c]));
        end
        w_fprod[0] = (FREQ_W+COORD_W)'(w_fmag[0]) * (FREQ_W+COORD_W)'(i_pix.out_y);
        w_fprod[1] = (FREQ_W+COORD_W)'(w_fmag[1]) * (FREQ_W+COORD_W)'(i_pix.out_x);
        w_all_ok = w_ok[0] && w_ok[1];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ac[0][0] <= i_pix.out_x;
            r_ac[0][1] <= i_pix.out_y;
            for (int c = 0; c < 2; c++) begin
                r_ad[0][c].dvd <= AD_W'({w_fprod[c], 8'b0});
                r_ad[0][c].rem <= '0;
                r_ad[0][c].quo <= '0;
                r_ad[0][c].neg <= r_freq[c][FREQ_W-1];
            end
            for (int k = 1; k <= AD_W; k++) begin
                for (int c = 0; c < 2; c++) begin
                    r_ad[k][c] <= adiv_step(r_ad[k-1][c], r_size[1-c]);
                    r_ac[k][c] <= r_ac[k-1][c];
                end
            end
            for (int c = 0; c < 2; c++) begin
                r_ang[c]   <= w_qlow[c] + r_phase[c];
                r_pc[0][c] <= r_ac[AD_W][c];
                r_mag[c]   <= SINE_ROM[w_addr[c]];
                r_sneg[c]  <= w_idx[c][ROM_AW+1];
                r_pc[1][c] <= r_pc[0][c];
                r_prod[c]  <= $signed({1'b0, r_amp[c]}) * w_sine[c];
                r_pc[2][c] <= r_pc[1][c];
                r_off[c]   <= r_prod[c][PROD_W-1] ? -$signed(OFF_W'(w_rnd[c]))
                                                  : $signed(OFF_W'(w_rnd[c]));
                r_pc[3][c] <= r_pc[2][c];
                r_sum[c]   <= $signed(SUM_W'(r_pc[3][c])) + SUM_W'(r_off[c])
                              - $signed(SUM_W'(r_amp[c]));
                r_num[c]   <= NUM_W'(r_sum[c]) * NUM_W'($signed({1'b0, r_sm1[c]}));
                r_wd[0][c].neg <= r_num[c][NUM_W-1];
                r_wd[0][c].acc <= r_num[c][NUM_W-1] ? MAG_W'(-r_num[c]) : MAG_W'(r_num[c]);
                r_wd[0][c].rem <= '0;
            end
            for (int k = 1; k <= MAG_W; k++) begin
                for (int c = 0; c < 2; c++) begin
                    r_wd[k][c] <= wdiv_step(r_wd[k-1][c], r_wdv[c]);
                end
            end
            r_src_x    <= w_all_ok ? r_wd[MAG_W][0].acc[COORD_W-1:0] : '0;
            r_src_y    <= w_all_ok ? r_wd[MAG_W][1].acc[COORD_W-1:0] : '0;
            r_in_range <= w_all_ok;
        end
    end

    assign o_src.valid    = r_ov;
    assign o_src.src_x    = r_src_x;
    assign o_src.src_y    = r_src_y;
    assign o_src.in_range = r_in_range;

`ifndef SYNTH
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_src.valid && !o_src.ready) |-> !i_pix.ready)
        else $error("input accepted while the output is stalled");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_vld[0])
        else $error("accepted transaction did not enter the pipeline");

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_src.valid && !o_src.in_range) |-> (o_src.src_x == '0 && o_src.src_y == '0))
        else $error("out of range result with nonzero coordinates");
`endif

endmodule

`default_nettype wire
